// File: rtl/tensor_polynomial_evaluator_core_defines.svh
// Assertion macros shared by the tensor polynomial evaluator RTL.
// Included by files that carry concurrent assertions; needs no package.
`ifndef TENSOR_POLYNOMIAL_EVALUATOR_CORE_DEFINES_SVH
`define TENSOR_POLYNOMIAL_EVALUATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpe assertion failed");
`define TPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpe assertion failed");
`else
`define TPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/tpe_pkg.sv
// Package of the tensor polynomial evaluator: widths, codes, types and tables.
// Used by every RTL module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package tpe_pkg;

    localparam int DIMS_DEF   = 4;
    localparam int POINTS_DEF = 4;
    localparam int DEPTH      = 256;
    localparam int ADDR_W     = 8;
    localparam int FEAT_N     = 4;
    localparam int DATA_W     = 32;
    localparam int SUM_W      = 48;
    localparam int FRAC       = 16;
    localparam int CFG_W      = 3;
    localparam int DIM_W      = 4;
    localparam int SLOT_N     = 8;
    localparam int DG_W       = 3;
    localparam int CNT_W      = 9;
    localparam int QDEPTH     = 2;

    localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sh0001_0000;

    localparam logic CFG_IDX_DIMS   = 1'b0;
    localparam logic CFG_IDX_POINTS = 1'b1;
    localparam logic [CFG_W-1:0] DIMS_RST   = 3'd1;
    localparam logic [CFG_W-1:0] POINTS_RST = 3'd3;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef logic [SLOT_N-1:0][DG_W-1:0] t_digits;

    typedef struct packed {
        logic [DIM_W-1:0] dims;
        logic [DIM_W-1:0] pts;
        logic [CNT_W-1:0] count;
        t_digits          start;
    } t_eff;

    typedef struct packed {
        logic                          is_eval;
        logic [ADDR_W-1:0]             idx;
        logic [DATA_W-1:0]             value;
        logic [FEAT_N-1:0][DATA_W-1:0] feat;
    } t_item;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_TERM,
        BK_MULT,
        BK_COEF,
        BK_ACC,
        BK_DONE
    } t_bk_state;

    // Digits of the last store index in base p, dimension 0 first.
    function automatic t_digits digits_of_last(input int p);
        t_digits d;
        int      rest;
        int      r;
        int      q;
        d    = '0;
        rest = DEPTH - 1;
        for (int n = 0; n < SLOT_N; n++) begin
            r = rest;
            q = 0;
            for (int k = 0; k < DEPTH; k++) begin
                if (r >= p) begin
                    r = r - p;
                    q = q + 1;
                end
            end
            d[n] = DG_W'(r);
            rest = q;
        end
        return d;
    endfunction

    // Start digits when the lattice is larger than the store, by points minus one.
    localparam t_digits LAST_DIGITS [SLOT_N] = '{
        digits_of_last(1), digits_of_last(2), digits_of_last(3), digits_of_last(4),
        digits_of_last(5), digits_of_last(6), digits_of_last(7), digits_of_last(8)
    };

endpackage
`default_nettype wire

// File: rtl/tpe_front.sv
// Front end: configuration registers, input handshake and item classification.
// Depends on tpe_pkg; feeds tpe_queue and hands the derived settings to tpe_back.
`timescale 1ns / 1ps
`default_nettype none
module tpe_front #(
    parameter int MAX_DIMS   = tpe_pkg::DIMS_DEF,
    parameter int MAX_POINTS = tpe_pkg::POINTS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic                       i_cfg_index,
    input  wire logic [tpe_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_action,
    input  wire logic [7:0]                 i_coef_index,
    input  wire logic signed [31:0]         i_coef_value,
    input  wire logic signed [31:0]         i_feature_0,
    input  wire logic signed [31:0]         i_feature_1,
    input  wire logic signed [31:0]         i_feature_2,
    input  wire logic signed [31:0]         i_feature_3,
    input  wire logic                       i_q_full,
    output logic                            o_push,
    output tpe_pkg::t_item                  o_item,
    output tpe_pkg::t_eff                   o_eff
);

    logic [tpe_pkg::CFG_W-1:0] r_dims;
    logic [tpe_pkg::CFG_W-1:0] r_pts;
    tpe_pkg::t_eff             w_eff;
    tpe_pkg::t_eff             r_eff;
    logic [tpe_pkg::DIM_W-1:0] w_pm1;
    logic [11:0]               w_cnt;
    logic                      w_capped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= tpe_pkg::DIMS_RST;
            r_pts  <= tpe_pkg::POINTS_RST;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == tpe_pkg::CFG_IDX_DIMS) begin
                r_dims <= i_cfg_wdata;
            end else begin
                r_pts <= i_cfg_wdata;
            end
        end
    end

    // Clamp the settings and size the lattice, capped at the store depth.
    always_comb begin
        w_eff.dims = {1'b0, r_dims};
        w_eff.pts  = {1'b0, r_pts};
        if (w_eff.dims == '0) w_eff.dims = tpe_pkg::DIM_W'(1);
        if (w_eff.dims > tpe_pkg::DIM_W'(MAX_DIMS)) w_eff.dims = tpe_pkg::DIM_W'(MAX_DIMS);
        if (w_eff.pts == '0) w_eff.pts = tpe_pkg::DIM_W'(1);
        if (w_eff.pts > tpe_pkg::DIM_W'(MAX_POINTS)) w_eff.pts = tpe_pkg::DIM_W'(MAX_POINTS);
        w_pm1    = w_eff.pts - tpe_pkg::DIM_W'(1);
        w_cnt    = 12'd1;
        w_capped = 1'b0;
        for (int i = 0; i < MAX_DIMS; i++) begin
            if (tpe_pkg::DIM_W'(i) < w_eff.dims) begin
                w_cnt = 12'(w_cnt * 12'(w_eff.pts));
                if (w_cnt > 12'(tpe_pkg::DEPTH)) begin
                    w_cnt    = 12'(tpe_pkg::DEPTH);
                    w_capped = 1'b1;
                end
            end
        end
        w_eff.count = w_cnt[tpe_pkg::CNT_W-1:0];
        if (w_capped) begin
            w_eff.start = tpe_pkg::LAST_DIGITS[w_pm1[2:0]];
        end else begin
            w_eff.start = '0;
            for (int n = 0; n < tpe_pkg::SLOT_N; n++) begin
                if (tpe_pkg::DIM_W'(n) < w_eff.dims) w_eff.start[n] = w_pm1[tpe_pkg::DG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eff <= w_eff;
    end

    assign o_eff      = r_eff;
    assign o_in_ready = !i_q_full;

    // Loads outside the lattice are dropped here and never reach the queue.
    assign o_push = i_in_valid && o_in_ready &&
                    ((i_action == tpe_pkg::ACT_EVAL) ||
                     ({1'b0, i_coef_index} < w_eff.count));

    always_comb begin
        o_item.is_eval = (i_action == tpe_pkg::ACT_EVAL);
        o_item.idx     = i_coef_index;
        o_item.value   = i_coef_value;
        o_item.feat[0] = i_feature_0;
        o_item.feat[1] = i_feature_1;
        o_item.feat[2] = i_feature_2;
        o_item.feat[3] = i_feature_3;
    end

endmodule
`default_nettype wire

// File: rtl/tpe_queue.sv
// Short queue of classified items between the front and the back end.
// Depends on tpe_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none
module tpe_queue (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  tpe_pkg::t_item  i_item,
    output logic            o_full,
    input  wire logic       i_pop,
    output logic            o_valid,
    output tpe_pkg::t_item  o_item
);

    localparam int PW = (tpe_pkg::QDEPTH > 1) ? $clog2(tpe_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(tpe_pkg::QDEPTH + 1);

    tpe_pkg::t_item r_mem [tpe_pkg::QDEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_cnt;
    logic           w_wr;
    logic           w_rd;

    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;
    assign o_full  = (r_cnt == CW'(tpe_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wptr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) r_wptr <= (r_wptr == PW'(tpe_pkg::QDEPTH - 1)) ? '0 : r_wptr + PW'(1);
            if (w_rd) r_rptr <= (r_rptr == PW'(tpe_pkg::QDEPTH - 1)) ? '0 : r_rptr + PW'(1);
            if (w_wr && !w_rd) r_cnt <= r_cnt + CW'(1);
            else if (w_rd && !w_wr) r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule
`default_nettype wire

// File: rtl/tpe_back.sv
// Back end: coefficient store, multiply-accumulate sequencer and result register.
// Depends on tpe_pkg; takes items from tpe_queue and settings from tpe_front.
`timescale 1ns / 1ps
`default_nettype none
module tpe_back #(
    parameter int MAX_DIMS = tpe_pkg::DIMS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_valid,
    input  tpe_pkg::t_item                  i_item,
    output logic                            o_pop,
    input  tpe_pkg::t_eff                   i_eff,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    output logic signed [47:0]              o_poly_value,
    output logic                            o_overflow
);

    localparam int DIM_IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam logic signed [47:0] SUM_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] SUM_MIN = {1'b1, {47{1'b0}}};
    localparam logic signed [31:0] MONO_MAX = {1'b0, {31{1'b1}}};
    localparam logic signed [31:0] MONO_MIN = {1'b1, {31{1'b0}}};

    tpe_pkg::t_bk_state r_state;
    tpe_pkg::t_bk_state n_state;

    logic [tpe_pkg::DATA_W-1:0]        r_mem [tpe_pkg::DEPTH];
    logic [tpe_pkg::DEPTH-1:0]         r_vld;
    logic signed [31:0]                r_rd;
    logic                              r_rd_ok;
    logic signed [31:0]                r_feat [MAX_DIMS];
    logic [tpe_pkg::DG_W-1:0]          r_dig  [MAX_DIMS];
    logic [tpe_pkg::DG_W-1:0]          n_dig  [MAX_DIMS];
    logic [tpe_pkg::CNT_W-1:0]         r_left;
    logic [tpe_pkg::DIM_W-1:0]         r_dn;
    logic [tpe_pkg::DG_W-1:0]          r_kk;
    logic [tpe_pkg::DIM_W-1:0]         r_dims;
    logic [tpe_pkg::DIM_W-1:0]         r_pts;
    logic signed [31:0]                r_mono;
    logic signed [47:0]                r_term;
    logic signed [47:0]                r_sum;
    logic                              r_ov;

    logic                              w_mem_we;
    logic                              w_mem_re;
    logic                              w_out_free;
    logic [tpe_pkg::ADDR_W-1:0]        w_flat;
    logic signed [31:0]                w_fsel;
    logic [tpe_pkg::DG_W-1:0]          w_dsel;
    logic signed [31:0]                w_coef;
    logic signed [31:0]                w_b;
    logic signed [63:0]                w_prod;
    logic signed [47:0]                w_sh;
    logic                              w_sat_ov;
    logic signed [31:0]                w_sat;
    logic signed [48:0]                w_acc_full;
    logic                              w_acc_ov;
    logic signed [47:0]                w_acc;
    logic                              w_borrow;

    assign w_out_free = !o_out_valid || i_out_ready;
    assign w_flat     = tpe_pkg::ADDR_W'(r_left - tpe_pkg::CNT_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tpe_pkg::BK_IDLE: if (i_q_valid && i_item.is_eval) n_state = tpe_pkg::BK_TERM;
            tpe_pkg::BK_TERM: n_state = tpe_pkg::BK_MULT;
            tpe_pkg::BK_MULT: if (r_dn == r_dims) n_state = tpe_pkg::BK_COEF;
            tpe_pkg::BK_COEF: n_state = tpe_pkg::BK_ACC;
            tpe_pkg::BK_ACC: begin
                if (r_left == tpe_pkg::CNT_W'(1)) n_state = tpe_pkg::BK_DONE;
                else n_state = tpe_pkg::BK_TERM;
            end
            tpe_pkg::BK_DONE: if (w_out_free) n_state = tpe_pkg::BK_IDLE;
            default: n_state = tpe_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = (r_state == tpe_pkg::BK_IDLE) && i_q_valid;
        w_mem_we = o_pop && !i_item.is_eval;
        w_mem_re = (r_state == tpe_pkg::BK_TERM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= tpe_pkg::BK_IDLE;
        else r_state <= n_state;
    end

    // Coefficient store; entries never loaded since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[i_item.idx] <= i_item.value;
        if (w_mem_re) begin
            r_rd    <= r_mem[w_flat];
            r_rd_ok <= r_vld[w_flat];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_mem_we) r_vld[i_item.idx] <= 1'b1;
    end

    // One shared multiplier: feature powers in the multiply state, the term after.
    assign w_fsel   = r_feat[r_dn[DIM_IW-1:0]];
    assign w_dsel   = r_dig[r_dn[DIM_IW-1:0]];
    assign w_coef   = r_rd_ok ? r_rd : '0;
    assign w_b      = (r_state == tpe_pkg::BK_COEF) ? w_coef : w_fsel;
    assign w_prod   = 64'(r_mono) * 64'(w_b);
    assign w_sh     = w_prod[63:tpe_pkg::FRAC];
    assign w_sat_ov = !((&w_sh[47:31]) || !(|w_sh[47:31]));
    assign w_sat    = w_sat_ov ? (w_sh[47] ? MONO_MIN : MONO_MAX) : w_sh[31:0];

    assign w_acc_full = {r_sum[47], r_sum} + {r_term[47], r_term};
    assign w_acc_ov   = w_acc_full[48] ^ w_acc_full[47];
    assign w_acc      = w_acc_ov ? (w_acc_full[48] ? SUM_MIN : SUM_MAX) : w_acc_full[47:0];

    // Step the lattice coordinates down by one in mixed radix.
    always_comb begin
        w_borrow = 1'b1;
        for (int n = 0; n < MAX_DIMS; n++) begin
            n_dig[n] = r_dig[n];
            if (w_borrow) begin
                if (r_dig[n] == '0) begin
                    n_dig[n] = tpe_pkg::DG_W'(r_pts - tpe_pkg::DIM_W'(1));
                end else begin
                    n_dig[n] = r_dig[n] - tpe_pkg::DG_W'(1);
                    w_borrow = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            tpe_pkg::BK_IDLE: begin
                if (o_pop && i_item.is_eval) begin
                    for (int n = 0; n < MAX_DIMS; n++) begin
                        r_feat[n] <= (n < tpe_pkg::FEAT_N) ?
                                     i_item.feat[(n < tpe_pkg::FEAT_N) ? n : 0] : '0;
                        r_dig[n]  <= i_eff.start[n];
                    end
                    r_left <= i_eff.count;
                    r_dims <= i_eff.dims;
                    r_pts  <= i_eff.pts;
                    r_sum  <= '0;
                    r_ov   <= 1'b0;
                end
            end
            tpe_pkg::BK_TERM: begin
                r_mono <= tpe_pkg::ONE_Q16;
                r_dn   <= '0;
                r_kk   <= '0;
            end
            tpe_pkg::BK_MULT: begin
                if (r_dn != r_dims) begin
                    if (r_kk == w_dsel) begin
                        r_dn <= r_dn + tpe_pkg::DIM_W'(1);
                        r_kk <= '0;
                    end else begin
                        r_mono <= w_sat;
                        r_ov   <= r_ov | w_sat_ov;
                        r_kk   <= r_kk + tpe_pkg::DG_W'(1);
                    end
                end
            end
            tpe_pkg::BK_COEF: r_term <= w_sh;
            tpe_pkg::BK_ACC: begin
                r_sum  <= w_acc;
                r_ov   <= r_ov | w_acc_ov;
                r_left <= r_left - tpe_pkg::CNT_W'(1);
                r_dig  <= n_dig;
            end
            tpe_pkg::BK_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == tpe_pkg::BK_DONE && w_out_free) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tpe_pkg::BK_DONE && w_out_free) begin
            o_poly_value <= r_sum;
            o_overflow   <= r_ov;
        end
    end

endmodule
`default_nettype wire

// File: rtl/tensor_polynomial_evaluator_core.sv
// Top level of the tensor polynomial evaluator: front end, queue and back end.
// Depends on tpe_pkg, tpe_front, tpe_queue, tpe_back and the defines header.
//
//  Port group  Handshake                 Contents
//  cfg         i_cfg_wr_en               i_cfg_index, i_cfg_wdata
//  in          i_in_valid / o_in_ready   i_action, i_coef_index, i_coef_value, i_feature_*
//  out         o_out_valid / i_out_ready o_poly_value, o_overflow
//
// A load transaction leaves the queue while the back end is idle and goes into the store; dropped loads never enter it.
// An evaluate transaction runs the term, multiply, coefficient and accumulate states for each lattice point, then
// waits in the done state for the output register; the single shared multiplier serialises this work.
// Reset is synchronous; the store reads as zero right after it, with no sweep.
// The front keeps accepting while the back end works until the queue is full.
`timescale 1ns / 1ps
`default_nettype none
`include "tensor_polynomial_evaluator_core_defines.svh"
module tensor_polynomial_evaluator_core #(
    parameter int MAX_DIMS   = tpe_pkg::DIMS_DEF,
    parameter int MAX_POINTS = tpe_pkg::POINTS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic                       i_cfg_index,
    input  wire logic [tpe_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_action,
    input  wire logic [7:0]                 i_coef_index,
    input  wire logic signed [31:0]         i_coef_value,
    input  wire logic signed [31:0]         i_feature_0,
    input  wire logic signed [31:0]         i_feature_1,
    input  wire logic signed [31:0]         i_feature_2,
    input  wire logic signed [31:0]         i_feature_3,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic signed [47:0]              o_poly_value,
    output logic                            o_overflow
);

    logic           w_push;
    logic           w_pop;
    logic           w_q_full;
    logic           w_q_valid;
    logic           w_out_hold;
    tpe_pkg::t_item w_in_item;
    tpe_pkg::t_item w_q_item;
    tpe_pkg::t_eff  w_eff;

    tpe_front #(
        .MAX_DIMS   (MAX_DIMS),
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_feature_0  (i_feature_0),
        .i_feature_1  (i_feature_1),
        .i_feature_2  (i_feature_2),
        .i_feature_3  (i_feature_3),
        .i_q_full     (w_q_full),
        .o_push       (w_push),
        .o_item       (w_in_item),
        .o_eff        (w_eff)
    );

    tpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    tpe_back #(
        .MAX_DIMS (MAX_DIMS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_item       (w_q_item),
        .o_pop        (w_pop),
        .i_eff        (w_eff),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_poly_value (o_poly_value),
        .o_overflow   (o_overflow)
    );

    assign w_out_hold = o_out_valid && !i_out_ready;

    // A result that is not taken stays offered with the same value.
    `TPE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_out_hold, o_out_valid && $stable(o_poly_value))
    // The back end only takes from a queue that holds a transaction.
    `TPE_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, w_pop, w_q_valid)
    // A full queue with no pop stays full in the next cycle.
    `TPE_ASSERT_NXT(a_full_holds, i_clk, i_rst_n, w_q_full && !w_pop, w_q_full)

endmodule
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench of tensor_polynomial_evaluator_core: coefficient loads
// and evaluations with random flow control, checked against an in-bench predictor.
// Depends on tpe_pkg and the RTL of the evaluator.
`timescale 1ns / 1ps
module testbench;

    localparam int IDLE_LIMIT = 60000;
    localparam int SETTLE     = 40;

    typedef struct {
        logic        action;
        logic [7:0]  idx;
        logic [31:0] coef;
        logic [31:0] feat [4];
    } poly_txn_t;

    typedef struct {
        logic [47:0] value;
        logic        ovf;
    } poly_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic i_cfg_index = tpe_pkg::CFG_IDX_DIMS;
    logic [tpe_pkg::CFG_W-1:0] i_cfg_wdata = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_action = tpe_pkg::ACT_LOAD;
    logic [7:0] i_coef_index = '0;
    logic signed [31:0] i_coef_value = '0;
    logic signed [31:0] i_feature_0 = '0;
    logic signed [31:0] i_feature_1 = '0;
    logic signed [31:0] i_feature_2 = '0;
    logic signed [31:0] i_feature_3 = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [47:0] o_poly_value;
    logic o_overflow;

    tensor_polynomial_evaluator_core uut (.*);

    always #4 i_clk = ~i_clk;

    // Predictor state: coefficient store and register copies.
    logic signed [31:0] coef_store [256];
    logic [2:0] dims_reg = tpe_pkg::DIMS_RST;
    logic [2:0] pts_reg = tpe_pkg::POINTS_RST;

    poly_txn_t    pending_txns [$];
    poly_result_t expected_values [$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  holdoff_cycles = 0;
    bit  in_fire = 0;

    function automatic void enqueue_txn(poly_txn_t t);
        pending_txns.insert(pending_txns.size(), t);
    endfunction

    function automatic int eff_dims();
        return (dims_reg < 1) ? 1 : (dims_reg > 4) ? 4 : int'(dims_reg);
    endfunction

    function automatic int eff_pts();
        return (pts_reg < 1) ? 1 : (pts_reg > 4) ? 4 : int'(pts_reg);
    endfunction

    function automatic int lattice_size();
        int c;
        c = 1;
        for (int n = 0; n < eff_dims(); n++) c = c * eff_pts();
        return (c > 256) ? 256 : c;
    endfunction

    // Evaluates the polynomial at the features, summing from the top index down.
    function automatic poly_result_t evaluate_poly(poly_txn_t t);
        poly_result_t r;
        longint sum, mono, term, f;
        int rest, crd, d, p;
        logic ovf;
        d = eff_dims();
        p = eff_pts();
        sum = 0;
        ovf = 0;
        for (int flat = lattice_size() - 1; flat >= 0; flat--) begin
            rest = flat;
            mono = 65536;
            for (int n = 0; n < d; n++) begin
                crd = rest % p;
                rest = rest / p;
                f = longint'($signed(t.feat[n]));
                for (int k = 0; k < crd; k++) begin
                    mono = (mono * f) >>> 16;
                    if (mono > 64'sd2147483647) begin
                        mono = 64'sd2147483647;
                        ovf = 1;
                    end else if (mono < -64'sd2147483648) begin
                        mono = -64'sd2147483648;
                        ovf = 1;
                    end
                end
            end
            term = (mono * longint'(coef_store[flat])) >>> 16;
            sum = sum + term;
            if (sum > 64'sd140737488355327) begin
                sum = 64'sd140737488355327;
                ovf = 1;
            end else if (sum < -64'sd140737488355328) begin
                sum = -64'sd140737488355328;
                ovf = 1;
            end
        end
        r.value = sum[47:0];
        r.ovf = ovf;
        return r;
    endfunction

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom();
            3: return 32'h0001_0000;
            4: return 32'hffff_0000;
            5: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_8000;
            default: return 32'(int'($urandom_range(0, 262143)) - 131072);
        endcase
    endfunction

    function automatic poly_txn_t make_txn(logic act, logic [7:0] idx, logic [31:0] coef);
        poly_txn_t t;
        t.action = act;
        t.idx = idx;
        t.coef = coef;
        for (int n = 0; n < 4; n++) t.feat[n] = rand_q16();
        return t;
    endfunction

    // Driver: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        poly_txn_t t;
        logic nxt_valid;
        nxt_valid = i_in_valid;
        if (!i_in_valid || in_fire) begin
            nxt_valid = 0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_txns.size() > 0) begin
                t = pending_txns.pop_front();
                nxt_valid = 1;
                i_action <= t.action;
                i_coef_index <= t.idx;
                i_coef_value <= t.coef;
                i_feature_0 <= t.feat[0];
                i_feature_1 <= t.feat[1];
                i_feature_2 <= t.feat[2];
                i_feature_3 <= t.feat[3];
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
        end
        i_in_valid <= nxt_valid;
    end

    // Receiver: its own stall pattern, plus a long hold-off when requested.
    int stall_mode = 0;
    int mode_left = 0;
    always @(negedge i_clk) begin
        logic rdy;
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(16, 96);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: rdy = 1;
            1: rdy = $urandom_range(0, 1);
            default: rdy = ($urandom_range(0, 3) == 0);
        endcase
        if (holdoff_cycles > 0) begin
            holdoff_cycles--;
            rdy = 0;
        end
        i_out_ready <= rdy;
    end

    // Monitor: checks results, predicts accepted transactions, watches for a hang.
    always @(posedge i_clk) begin
        poly_result_t want;
        poly_txn_t t;
        bit progress;
        progress = 0;
        in_fire = 0;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            progress = 1;
            if (expected_values.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h ovf=%b", o_poly_value, o_overflow);
            end else begin
                want = expected_values.pop_front();
                if (o_poly_value !== want.value || o_overflow !== want.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value=%h ovf=%b, got value=%h ovf=%b",
                                 want.value, want.ovf, o_poly_value, o_overflow);
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            progress = 1;
            in_fire = 1;
            t.action = i_action;
            t.idx = i_coef_index;
            t.coef = i_coef_value;
            t.feat[0] = i_feature_0;
            t.feat[1] = i_feature_1;
            t.feat[2] = i_feature_2;
            t.feat[3] = i_feature_3;
            if (t.action == tpe_pkg::ACT_EVAL)
                expected_values.insert(expected_values.size(), evaluate_poly(t));
            else if (int'(t.idx) < lattice_size())
                coef_store[t.idx] = t.coef;
        end
        idle_cycles = progress ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [2:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        if (idx == tpe_pkg::CFG_IDX_DIMS) dims_reg = val;
        else pts_reg = val;
        @(negedge i_clk);
        i_cfg_wr_en <= 0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_txns.size() > 0 || i_in_valid || expected_values.size() > 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Mostly loads inside the lattice, mixed at random with evaluations and some stray loads.
    task automatic random_phase(int n_items);
        int r, cnt;
        cnt = lattice_size();
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                enqueue_txn(make_txn(tpe_pkg::ACT_LOAD, 8'($urandom_range(0, cnt - 1)),
                                     rand_q16()));
            else if (r < 62)
                enqueue_txn(make_txn(tpe_pkg::ACT_LOAD, 8'($urandom()), rand_q16()));
            else
                enqueue_txn(make_txn(tpe_pkg::ACT_EVAL, 8'($urandom()), $urandom()));
        end
    endtask

    // {dims, points, items}; out-of-range register values exercise the clamping.
    int phase_cfg [14][3] = '{
        '{2, 4, 110}, '{1, 1, 80}, '{0, 0, 60}, '{3, 2, 110}, '{1, 4, 110},
        '{4, 4, 30}, '{2, 3, 110}, '{7, 7, 25}, '{4, 2, 90}, '{3, 3, 40},
        '{1, 5, 110}, '{6, 1, 60}, '{2, 2, 110}, '{1, 3, 100}
    };

    initial begin
        poly_txn_t t;
        for (int i = 0; i < 256; i++) coef_store[i] = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Reset configuration: one dimension, three points.
        enqueue_txn(make_txn(tpe_pkg::ACT_EVAL, 8'hff, 32'hffff_ffff));
        enqueue_txn(make_txn(tpe_pkg::ACT_LOAD, 8'd0, 32'h7fff_ffff));
        enqueue_txn(make_txn(tpe_pkg::ACT_LOAD, 8'd2, 32'h8000_0000));
        enqueue_txn(make_txn(tpe_pkg::ACT_LOAD, 8'd3, 32'h1234_5678));
        enqueue_txn(make_txn(tpe_pkg::ACT_LOAD, 8'd255, 32'h0001_0000));
        enqueue_txn(make_txn(tpe_pkg::ACT_LOAD, 8'd1, 32'hfffe_8000));
        t = make_txn(tpe_pkg::ACT_EVAL, 8'd0, 32'd0);
        t.feat = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
        enqueue_txn(t);
        t.feat = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
        enqueue_txn(t);
        t.feat = '{32'h0001_0000, 32'h0, 32'h0, 32'h0};
        enqueue_txn(t);
        t.feat = '{32'hfffe_8000, 32'h0, 32'h0, 32'h0};
        enqueue_txn(t);
        t.feat = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
        enqueue_txn(t);
        t.feat = '{32'h0, 32'h0, 32'h0, 32'h0};
        enqueue_txn(t);
        // Large coefficients at a large feature drive the sum into saturation.
        enqueue_txn(make_txn(tpe_pkg::ACT_LOAD, 8'd1, 32'h7fff_ffff));
        enqueue_txn(make_txn(tpe_pkg::ACT_LOAD, 8'd2, 32'h7fff_ffff));
        t.feat = '{32'h7fff_ffff, 32'h0, 32'h0, 32'h0};
        enqueue_txn(t);
        t.feat = '{32'h8000_0000, 32'h0, 32'h0, 32'h0};
        enqueue_txn(t);
        random_phase(40);
        wait_drained();

        foreach (phase_cfg[p]) begin
            write_reg(tpe_pkg::CFG_IDX_DIMS, 3'(phase_cfg[p][0]));
            write_reg(tpe_pkg::CFG_IDX_POINTS, 3'(phase_cfg[p][1]));
            // Hold the receiver off long enough for the input side to back up.
            if (p == 3) holdoff_cycles = 3000;
            random_phase(phase_cfg[p][2]);
            wait_drained();
        end

        if (mismatches == 0 && expected_values.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/tpe_pkg.sv
rtl/tpe_front.sv
rtl/tpe_queue.sv
rtl/tpe_back.sv
rtl/tensor_polynomial_evaluator_core.sv
test/testbench.sv
